FILE: hw/rtl/opl_pkg.sv
// Shared types and constants for the ordered point list engine.
// No dependencies; imported by opl_ctrl, opl_datapath and the top level.
`default_nettype none

package opl_pkg;

   localparam int DEFAULT_STORE_DEPTH = 64;

   localparam int ACTION_W = 3;
   localparam int POS_W    = 7;
   localparam int COORD_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int POINT_W  = 2 * COORD_W;

   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 80;

   localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FRONT  = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_BACK   = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic capture;
      logic eval;
      logic shift;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic                ok;
      logic [ACTION_W-1:0] action;
      logic                shift_done;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/opl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module opl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/opl_ctrl.sv
// Sequencer for the ordered point list engine: handshakes and step control.
// Depends on opl_pkg; drives opl_datapath through dp_cmd_type.
`default_nettype none

module opl_ctrl
   import opl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output dp_cmd_type      cmd,
   input  wire dp_sts_type sts
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.eval = 1'b1;
            if (sts.ok && (sts.action inside {ACT_INSERT, ACT_ERASE})) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/opl_datapath.sv
// Datapath of the ordered point list engine: count, capacity, status,
// shift pointers and result register. Depends on opl_pkg; drives opl_ram.
`default_nettype none

module opl_datapath
   import opl_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [REQ_TDATA_W-1:0]         req_tdata,
   output logic      [RSP_TDATA_W-1:0]         rsp_tdata,
   input  wire dp_cmd_type                     cmd,
   output dp_sts_type                          sts,
   output logic                                ram_wr_en,
   output logic      [$clog2(STORE_DEPTH)-1:0] ram_wr_addr,
   output logic      [POINT_W-1:0]             ram_wr_data,
   output logic                                ram_rd_en,
   output logic      [$clog2(STORE_DEPTH)-1:0] ram_rd_addr,
   input  wire logic [POINT_W-1:0]             ram_rd_data
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_WC = (CNT_W + 1)'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);

   // latched request
   logic [ACTION_W-1:0] action_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POINT_W-1:0]  point_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // shift engine
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic              dir_up_ff, dir_up_in;
   logic              wpend_ff, wpend_in;
   logic [ADDR_W-1:0] waddr_ff, waddr_in;

   logic [RSP_TDATA_W-1:0] rsp_ff;

   logic [CMP_W-1:0]    pos_ext, cnt_ext;
   logic [STATUS_W-1:0] status_comb;
   logic                is_read;
   logic [CNT_W:0]      cap_dbl;
   logic [CNT_W-1:0]    cap_grown;
   logic [CMP_W-1:0]    ins_moves, ers_moves, ers_src, back_idx;
   logic [ADDR_W-1:0]   pos_addr, cnt_addr;
   logic                shift_done;
   logic [POINT_W-1:0]  rd_point;
   logic [COUNT_W-1:0]  count_out, cap_out;

   assign pos_ext   = CMP_W'(pos_ff);
   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_addr  = pos_ext[ADDR_W-1:0];
   assign cnt_addr  = cnt_ext[ADDR_W-1:0];
   assign ins_moves = cnt_ext - pos_ext;
   assign ers_moves = cnt_ext - pos_ext - CMP_W'(1);
   assign ers_src   = pos_ext + CMP_W'(1);
   assign back_idx  = cnt_ext - CMP_W'(1);
   assign is_read   = action_ff inside {ACT_READ, ACT_FRONT, ACT_BACK};

   always_comb begin
      status_comb = ST_OK;
      case (action_ff)
         ACT_PUSH: begin
            if (count_ff == DEPTH_C) status_comb = ST_FULL;
         end
         ACT_POP, ACT_FRONT, ACT_BACK: begin
            if (count_ff == '0) status_comb = ST_EMPTY;
         end
         ACT_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_comb = ST_RANGE;
            end else if (count_ff == DEPTH_C) begin
               status_comb = ST_FULL;
            end
         end
         ACT_ERASE, ACT_READ: begin
            if (pos_ext >= cnt_ext) status_comb = ST_RANGE;
         end
         default: begin
            status_comb = ST_OK;
         end
      endcase
   end

   // capacity after a growth step: 0 -> 1, then doubling, capped at depth
   always_comb begin
      cap_dbl = {cap_ff, 1'b0};
      if (count_ff != cap_ff) begin
         cap_grown = cap_ff;
      end else if (cap_ff == '0) begin
         cap_grown = ONE_C;
      end else if (cap_dbl > DEPTH_WC) begin
         cap_grown = DEPTH_C;
      end else begin
         cap_grown = cap_dbl[CNT_W-1:0];
      end
   end

   assign shift_done = (rem_ff == '0) && !wpend_ff;

   always_comb begin
      count_in    = count_ff;
      cap_in      = cap_ff;
      status_in   = status_ff;
      rem_in      = rem_ff;
      src_in      = src_ff;
      dir_up_in   = dir_up_ff;
      wpend_in    = wpend_ff;
      waddr_in    = waddr_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_addr;
      ram_wr_data = point_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_addr;

      if (cmd.eval) begin
         status_in = status_comb;
         wpend_in  = 1'b0;
         if (status_comb == ST_OK) begin
            case (action_ff)
               ACT_PUSH: begin
                  ram_wr_en = 1'b1;
                  cap_in    = cap_grown;
                  count_in  = count_ff + ONE_C;
               end
               ACT_POP: begin
                  count_in = count_ff - ONE_C;
               end
               ACT_INSERT: begin
                  rem_in    = ins_moves[CNT_W-1:0];
                  src_in    = back_idx[ADDR_W-1:0];
                  dir_up_in = 1'b0;
               end
               ACT_ERASE: begin
                  rem_in    = ers_moves[CNT_W-1:0];
                  src_in    = ers_src[ADDR_W-1:0];
                  dir_up_in = 1'b1;
               end
               ACT_READ: begin
                  ram_rd_en = 1'b1;
               end
               ACT_FRONT: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
               end
               ACT_BACK: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = back_idx[ADDR_W-1:0];
               end
               default: begin
                  count_in = '0;
               end
            endcase
         end
      end

      if (cmd.shift) begin
         if (wpend_ff) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = waddr_ff;
            ram_wr_data = ram_rd_data;
         end
         if (rem_ff != '0) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = src_ff;
            wpend_in    = 1'b1;
            waddr_in    = dir_up_ff ? src_ff - ADDR_W'(1) : src_ff + ADDR_W'(1);
            src_in      = dir_up_ff ? src_ff + ADDR_W'(1) : src_ff - ADDR_W'(1);
            rem_in      = rem_ff - ONE_C;
         end else begin
            wpend_in = 1'b0;
         end
         if (shift_done) begin
            if (action_ff == ACT_INSERT) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pos_addr;
               ram_wr_data = point_ff;
               cap_in      = cap_grown;
               count_in    = count_ff + ONE_C;
            end else begin
               count_in = count_ff - ONE_C;
            end
         end
      end
   end

   assign rd_point  = (status_ff == ST_OK && is_read) ? ram_rd_data : '0;
   assign count_out = cnt_ext[COUNT_W-1:0];
   assign cap_out   = COUNT_W'(CMP_W'(cap_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= '0;
         wpend_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         count_ff <= count_in;
         cap_ff   <= cap_in;
         wpend_ff <= wpend_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      src_ff    <= src_in;
      dir_up_ff <= dir_up_in;
      waddr_ff  <= waddr_in;
      if (cmd.capture) begin
         action_ff <= req_tdata[ACTION_W-1:0];
         pos_ff    <= req_tdata[ACTION_W +: POS_W];
         point_ff  <= req_tdata[ACTION_W + POS_W +: POINT_W];
      end
      if (cmd.load_rsp) begin
         rsp_ff <= {cap_out, count_out, rd_point, status_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

   assign sts.ok         = (status_comb == ST_OK);
   assign sts.action     = action_ff;
   assign sts.shift_done = shift_done;

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_point_list_engine.sv
// Top level of the ordered point list engine: sequencer, datapath and store.
// Depends on opl_pkg, opl_ram, opl_ctrl and opl_datapath.
//
//   channel  dir  tdata fields (lsb first)
//   req_     in   action[3] position[7] point_x[32] point_y[32] zero pad[6]
//   rsp_     out  status[2] read_x[32] read_y[32] count[7] reported_capacity[7]
//
// One item at a time. Push, pop, clear and reads go from accept through the check
// and done states to the result. Insert and erase that pass the check add a shift
// state in between, bound by the store's single read and single write port
// moving one entry a cycle.
// Reset clears count and capacity; the point store is not cleared.
// A result waiting on rsp_tready holds in the output register while the next
// beat is accepted and worked; only the following result waits for it.
`default_nettype none

module ordered_point_list_engine
   import opl_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // action, position, point_x, point_y
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata    // status, read_x, read_y, count, cap
);

   localparam int ADDR_W = $clog2(STORE_DEPTH);

   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [POINT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [POINT_W-1:0] ram_rd_data;

   opl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   opl_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .sts         (sts),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   opl_ram #(
      .WIDTH (POINT_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
